// ===== design/tun_pkg.sv =====
`timescale 1ns / 1ps
// Package for the triangle unit normal pipeline: stage counts, widths and types.
// No dependencies; every other design file but tun_if imports it.
package tun_pkg;

    localparam int SQRT_STAGES = 31;
    localparam int DIV_STAGES  = 31;
    localparam int MAG_W       = 63;
    localparam int NMAG_W      = 30;
    localparam int SUM_W       = 62;
    localparam int LEN_W       = 31;
    localparam int NUM_W       = 61;
    localparam int QUO_W       = 31;
    localparam int NORM_POS    = 29;
    localparam int EDGE_FRAC   = 30;
    localparam int OUT_FRAC    = 14;

    typedef logic signed [63:0] t_comp;
    typedef logic signed [31:0] t_unit;
    typedef logic [NMAG_W-1:0]  t_nmag;
    typedef logic [NUM_W-1:0]   t_num;
    typedef logic [QUO_W-1:0]   t_quo;
    typedef logic [LEN_W-1:0]   t_len;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
        logic       tag;
    } t_side;

endpackage

// ===== design/tun_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for vertex input and normal output transfers.
// Depends on nothing beyond the language.
interface tun_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_a_x;
    logic signed [31:0] vertex_a_y;
    logic signed [31:0] vertex_a_z;
    logic signed [31:0] vertex_b_x;
    logic signed [31:0] vertex_b_y;
    logic signed [31:0] vertex_b_z;
    logic signed [31:0] vertex_c_x;
    logic signed [31:0] vertex_c_y;
    logic signed [31:0] vertex_c_z;

    modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                    vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, input ready);
    modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                  vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, output ready);
endinterface

interface tun_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== design/tun_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
// Depends on tun_pkg.
module tun_isqrt import tun_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SUM_W-1:0] i_val,
    output logic             o_valid,
    output t_len             o_root
);

    logic             r_valid [SQRT_STAGES];
    logic [32:0]      r_rem   [SQRT_STAGES];
    t_len             r_root  [SQRT_STAGES];
    logic [SUM_W-1:0] r_val   [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            logic             p_valid;
            logic [32:0]      p_rem;
            t_len             p_root;
            logic [SUM_W-1:0] p_val;
            logic [33:0]      cur;
            logic [33:0]      trial;
            logic [32:0]      n_rem;
            t_len             n_root;

            if (k == 0) begin : g_first
                assign p_valid = i_valid;
                assign p_rem   = '0;
                assign p_root  = '0;
                assign p_val   = i_val;
            end else begin : g_next
                assign p_valid = r_valid[k-1];
                assign p_rem   = r_rem[k-1];
                assign p_root  = r_root[k-1];
                assign p_val   = r_val[k-1];
            end

            always_comb begin
                cur   = {p_rem[31:0], p_val[SUM_W-1-2*k -: 2]};
                trial = {1'b0, p_root, 2'b01};
                if (cur >= trial) begin
                    n_rem  = 33'(cur - trial);
                    n_root = {p_root[LEN_W-2:0], 1'b1};
                end else begin
                    n_rem  = cur[32:0];
                    n_root = {p_root[LEN_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= p_valid;
                end
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                    r_val[k]  <= p_val;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];

endmodule

// ===== design/tun_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on tun_pkg.
module tun_div import tun_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_num [2:0] i_num,
    input  t_len       i_den,
    output logic       o_valid,
    output t_quo [2:0] o_quo
);

    logic             r_valid [DIV_STAGES];
    t_len             r_den   [DIV_STAGES];
    logic [2:0][30:0] r_rem   [DIV_STAGES];
    t_quo [2:0]       r_quo   [DIV_STAGES];
    logic [2:0][30:0] r_low   [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            logic             p_valid;
            t_len             p_den;
            logic [2:0][30:0] p_rem;
            t_quo [2:0]       p_quo;
            logic [2:0][30:0] p_low;
            logic [2:0][30:0] n_rem;
            t_quo [2:0]       n_quo;

            if (k == 0) begin : g_first
                assign p_valid = i_valid;
                assign p_den   = i_den;
                for (genvar l = 0; l < 3; l++) begin : g_lane
                    assign p_rem[l] = {1'b0, i_num[l][NUM_W-1:QUO_W]};
                    assign p_low[l] = i_num[l][QUO_W-1:0];
                    assign p_quo[l] = '0;
                end
            end else begin : g_next
                assign p_valid = r_valid[k-1];
                assign p_den   = r_den[k-1];
                assign p_rem   = r_rem[k-1];
                assign p_quo   = r_quo[k-1];
                assign p_low   = r_low[k-1];
            end

            always_comb begin
                logic [31:0] cur;
                for (int l = 0; l < 3; l++) begin
                    cur = {p_rem[l], p_low[l][QUO_W-1-k]};
                    if (cur >= {1'b0, p_den}) begin
                        n_rem[l] = 31'(cur - {1'b0, p_den});
                        n_quo[l] = {p_quo[l][QUO_W-2:0], 1'b1};
                    end else begin
                        n_rem[l] = cur[30:0];
                        n_quo[l] = {p_quo[l][QUO_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= p_valid;
                end
                if (i_en) begin
                    r_den[k] <= p_den;
                    r_rem[k] <= n_rem;
                    r_quo[k] <= n_quo;
                    r_low[k] <= p_low;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];

endmodule

// ===== design/tun_unitize.sv =====
`timescale 1ns / 1ps
// Scales a three-component vector to unit length: normalize, sum of squares, root, divide.
// Depends on tun_pkg, tun_isqrt and tun_div.
module tun_unitize import tun_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic        i_tag,
    input  logic        i_frac_short,
    input  t_comp [2:0] i_vec,
    output logic        o_valid,
    output logic        o_tag,
    output logic        o_zero,
    output t_unit [2:0] o_unit
);

    logic                   r0_valid, r0_tag;
    logic [2:0]             r0_neg;
    logic [2:0][MAG_W-1:0]  r0_mag;

    logic                   r1_valid, r1_tag;
    logic [2:0]             r1_neg;
    logic [2:0][MAG_W-1:0]  r1_mag;
    logic [MAG_W-1:0]       r1_or;

    logic                   r2_valid, r2_tag, r2_zero;
    logic [2:0]             r2_neg;
    logic [2:0][MAG_W-1:0]  r2_mag;
    logic [2:0]             r2_grp;
    logic [7:0]             r2_byte;

    logic                   r3_valid, r3_tag, r3_zero;
    logic [2:0]             r3_neg;
    logic [2:0][MAG_W-1:0]  r3_mag;
    logic [5:0]             r3_pos;

    logic                   r4_valid;
    t_side                  r4_side;
    t_nmag [2:0]            r4_mag;

    logic                   r5_valid;
    t_side                  r5_side;
    t_nmag [2:0]            r5_mag;
    logic [2:0][59:0]       r5_sq;

    logic                   r6_valid;
    t_side                  r6_side;
    t_nmag [2:0]            r6_mag;
    logic [SUM_W-1:0]       r6_sum;

    t_side                  r_sq_side [SQRT_STAGES];
    t_nmag [2:0]            r_sq_mag  [SQRT_STAGES];

    logic                   sq_valid;
    t_len                   sq_root;

    logic                   r7_valid;
    t_side                  r7_side;
    t_num [2:0]             r7_num;
    t_len                   r7_den;

    t_side                  r_dv_side [DIV_STAGES];

    logic                   dv_valid;
    t_quo [2:0]             dv_quo;

    logic                   r8_valid;
    t_side                  r8_side;
    t_unit [2:0]            r8_unit;

    logic [2:0]             n0_neg;
    logic [2:0][MAG_W-1:0]  n0_mag;
    logic [2:0]             n2_grp;
    logic [7:0]             n2_byte;
    logic [2:0]             n3_bit;
    t_nmag [2:0]            n4_mag;
    t_num [2:0]             n7_num;
    t_unit [2:0]            n8_unit;

    always_comb begin
        logic [63:0] neg_val;
        for (int l = 0; l < 3; l++) begin
            n0_neg[l] = i_vec[l][63];
            neg_val   = 64'(-i_vec[l]);
            n0_mag[l] = n0_neg[l] ? neg_val[MAG_W-1:0] : i_vec[l][MAG_W-1:0];
        end
    end

    always_comb begin
        logic [63:0] wide;
        wide    = {1'b0, r1_or};
        n2_grp  = '0;
        n2_byte = '0;
        for (int g = 0; g < 8; g++) begin
            if (wide[g*8 +: 8] != 8'd0) begin
                n2_grp  = 3'(g);
                n2_byte = wide[g*8 +: 8];
            end
        end
    end

    always_comb begin
        n3_bit = '0;
        for (int b = 0; b < 8; b++) begin
            if (r2_byte[b]) begin
                n3_bit = 3'(b);
            end
        end
    end

    always_comb begin
        logic [MAG_W-1:0] sh;
        for (int l = 0; l < 3; l++) begin
            if (r3_pos > 6'(NORM_POS)) begin
                sh = r3_mag[l] >> (r3_pos - 6'(NORM_POS));
            end else begin
                sh = r3_mag[l] << (6'(NORM_POS) - r3_pos);
            end
            n4_mag[l] = sh[NMAG_W-1:0];
        end
    end

    always_comb begin
        t_num half;
        half = t_num'(sq_root >> 1);
        for (int l = 0; l < 3; l++) begin
            if (i_frac_short) begin
                n7_num[l] = (t_num'(r_sq_mag[SQRT_STAGES-1][l]) << OUT_FRAC) + half;
            end else begin
                n7_num[l] = (t_num'(r_sq_mag[SQRT_STAGES-1][l]) << EDGE_FRAC) + half;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_dv_side[DIV_STAGES-1].zero) begin
                n8_unit[l] = '0;
            end else if (r_dv_side[DIV_STAGES-1].neg[l]) begin
                n8_unit[l] = -$signed({1'b0, dv_quo[l]});
            end else begin
                n8_unit[l] = $signed({1'b0, dv_quo[l]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= sq_valid;
            r8_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_tag  <= i_tag;
            r0_neg  <= n0_neg;
            r0_mag  <= n0_mag;

            r1_tag  <= r0_tag;
            r1_neg  <= r0_neg;
            r1_mag  <= r0_mag;
            r1_or   <= r0_mag[0] | r0_mag[1] | r0_mag[2];

            r2_tag  <= r1_tag;
            r2_neg  <= r1_neg;
            r2_mag  <= r1_mag;
            r2_zero <= (r1_or == '0);
            r2_grp  <= n2_grp;
            r2_byte <= n2_byte;

            r3_tag  <= r2_tag;
            r3_neg  <= r2_neg;
            r3_mag  <= r2_mag;
            r3_zero <= r2_zero;
            r3_pos  <= {r2_grp, n3_bit};

            r4_side <= '{neg: r3_neg, zero: r3_zero, tag: r3_tag};
            r4_mag  <= n4_mag;

            r5_side <= r4_side;
            r5_mag  <= r4_mag;
            for (int l = 0; l < 3; l++) begin
                r5_sq[l] <= r4_mag[l] * r4_mag[l];
            end

            r6_side <= r5_side;
            r6_mag  <= r5_mag;
            r6_sum  <= SUM_W'(r5_sq[0]) + SUM_W'(r5_sq[1]) + SUM_W'(r5_sq[2]);

            r_sq_side[0] <= r6_side;
            r_sq_mag[0]  <= r6_mag;
            for (int s = 1; s < SQRT_STAGES; s++) begin
                r_sq_side[s] <= r_sq_side[s-1];
                r_sq_mag[s]  <= r_sq_mag[s-1];
            end

            r7_side <= r_sq_side[SQRT_STAGES-1];
            r7_num  <= n7_num;
            r7_den  <= sq_root;

            r_dv_side[0] <= r7_side;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_dv_side[s] <= r_dv_side[s-1];
            end

            r8_side <= r_dv_side[DIV_STAGES-1];
            r8_unit <= n8_unit;
        end
    end

    tun_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r6_valid),
        .i_val   (r6_sum),
        .o_valid (sq_valid),
        .o_root  (sq_root)
    );

    tun_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r7_valid),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .o_valid (dv_valid),
        .o_quo   (dv_quo)
    );

    assign o_valid = r8_valid;
    assign o_tag   = r8_side.tag;
    assign o_zero  = r8_side.zero;
    assign o_unit  = r8_unit;

endmodule

// ===== design/triangle_unit_normal.sv =====
`timescale 1ns / 1ps
// Channel     Direction  Content
// i_in        sink       vertices A, B, C, signed Q16.16
// o_out       source     unit normal, signed Q2.14, and degenerate flag
//
// One triangle is accepted per cycle unless o_out stalls; each result goes through
// the two unit-length scalers (31-stage square root and 31-stage divider each).
// Reset clears only the valid bits. A stall on o_out freezes the whole pipeline,
// the last stage being the output register; no transfer is lost or repeated.
// Depends on tun_pkg, tun_if and tun_unitize.
module triangle_unit_normal import tun_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tun_in_if.sink    i_in,
    tun_out_if.source o_out
);

    logic        en;
    logic        r_e_valid;
    t_comp [2:0] r_e1;
    t_comp [2:0] r_e2;

    logic        u1_valid, u1_tag, u1_zero;
    logic        u2_valid, u2_tag, u2_zero;
    t_unit [2:0] u1_unit;
    t_unit [2:0] u2_unit;

    logic        r_x1_valid, r_x1_ok;
    t_comp [5:0] r_x1_prod;
    logic        r_x2_valid, r_x2_ok;
    t_comp [2:0] r_x2_cross;

    logic        un_valid, un_tag, un_zero;
    t_unit [2:0] un_unit;

    logic               r_out_valid;
    logic signed [15:0] r_out_x, r_out_y, r_out_z;
    logic               r_out_deg;
    logic               deg;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid   <= 1'b0;
            r_x1_valid  <= 1'b0;
            r_x2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_e_valid   <= i_in.valid;
            r_x1_valid  <= u1_valid;
            r_x2_valid  <= r_x1_valid;
            r_out_valid <= un_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1[0] <= t_comp'(i_in.vertex_c_x) - t_comp'(i_in.vertex_b_x);
            r_e1[1] <= t_comp'(i_in.vertex_c_y) - t_comp'(i_in.vertex_b_y);
            r_e1[2] <= t_comp'(i_in.vertex_c_z) - t_comp'(i_in.vertex_b_z);
            r_e2[0] <= t_comp'(i_in.vertex_c_x) - t_comp'(i_in.vertex_a_x);
            r_e2[1] <= t_comp'(i_in.vertex_c_y) - t_comp'(i_in.vertex_a_y);
            r_e2[2] <= t_comp'(i_in.vertex_c_z) - t_comp'(i_in.vertex_a_z);

            r_x1_ok      <= !u1_zero && !u2_zero && (u1_tag == u2_tag);
            r_x1_prod[0] <= u1_unit[1] * u2_unit[2];
            r_x1_prod[1] <= u1_unit[2] * u2_unit[1];
            r_x1_prod[2] <= u1_unit[2] * u2_unit[0];
            r_x1_prod[3] <= u1_unit[0] * u2_unit[2];
            r_x1_prod[4] <= u1_unit[0] * u2_unit[1];
            r_x1_prod[5] <= u1_unit[1] * u2_unit[0];

            r_x2_ok       <= r_x1_ok;
            r_x2_cross[0] <= r_x1_prod[0] - r_x1_prod[1];
            r_x2_cross[1] <= r_x1_prod[2] - r_x1_prod[3];
            r_x2_cross[2] <= r_x1_prod[4] - r_x1_prod[5];

            r_out_deg <= deg;
            r_out_x   <= deg ? 16'sd0 : un_unit[0][15:0];
            r_out_y   <= deg ? 16'sd0 : un_unit[1][15:0];
            r_out_z   <= deg ? 16'sd0 : un_unit[2][15:0];
        end
    end

    assign deg = !un_tag || un_zero;

    tun_unitize u_unit_e1 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (r_e_valid),
        .i_tag        (1'b0),
        .i_frac_short (1'b0),
        .i_vec        (r_e1),
        .o_valid      (u1_valid),
        .o_tag        (u1_tag),
        .o_zero       (u1_zero),
        .o_unit       (u1_unit)
    );

    tun_unitize u_unit_e2 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (r_e_valid),
        .i_tag        (1'b0),
        .i_frac_short (1'b0),
        .i_vec        (r_e2),
        .o_valid      (u2_valid),
        .o_tag        (u2_tag),
        .o_zero       (u2_zero),
        .o_unit       (u2_unit)
    );

    tun_unitize u_unit_n (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (r_x2_valid),
        .i_tag        (r_x2_ok),
        .i_frac_short (1'b1),
        .i_vec        (r_x2_cross),
        .o_valid      (un_valid),
        .o_tag        (un_tag),
        .o_zero       (un_zero),
        .o_unit       (un_unit)
    );

    assign o_out.valid      = r_out_valid;
    assign o_out.normal_x   = r_out_x;
    assign o_out.normal_y   = r_out_y;
    assign o_out.normal_z   = r_out_z;
    assign o_out.degenerate = r_out_deg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for triangle_unit_normal: drives vertex transfers with random gaps,
// predicts unlisted unit normals in integer arithmetic and checks every result.
// Depends on tun_pkg, tun_if and the triangle_unit_normal design files.
module tb import tun_pkg::*; ();

    typedef struct {
        logic signed [31:0] v[9];
    } t_tri;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               degen;
    } t_norm;

    typedef struct {
        t_tri  tri_in;
        bit    typed;
        t_norm want;
    } t_row;

    localparam int LATENCY   = 146;
    localparam int N_RANDOM  = 1530;
    localparam int WDOG_MAX  = 5000;
    localparam int LONG_HOLD = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    tun_in_if  in_ch ();
    tun_out_if out_ch ();

    triangle_unit_normal DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_norm normal_queue[$];
    int    n_errors = 0;
    int    idle_cycles = 0;
    bit    stim_done = 1'b0;
    bit    hold_sink = 1'b0;
    bit    sink_fast = 1'b0;

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit scale_unit(input logic signed [63:0] vec[3], input int frac,
                                      output logic signed [63:0] res[3]);
        logic [63:0] mag[3];
        bit          neg[3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = vec[i] < 0;
            mag[i] = neg[i] ? -vec[i] : vec[i];
            if (mag[i] > mx) mx = mag[i];
        end
        for (int i = 0; i < 3; i++) res[i] = 0;
        if (mx == 0) return 1'b0;
        while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            mx = mx << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << frac) + (len >> 1)) / len;
            res[i] = neg[i] ? -$signed(q) : $signed(q);
        end
        return 1'b1;
    endfunction

    function automatic t_norm face_normal(t_tri t);
        logic signed [63:0] e1[3];
        logic signed [63:0] e2[3];
        logic signed [63:0] u1[3];
        logic signed [63:0] u2[3];
        logic signed [63:0] cr[3];
        logic signed [63:0] n[3];
        bit                 ok;
        t_norm              r;
        for (int i = 0; i < 3; i++) begin
            e1[i] = 64'(t.v[6+i]) - 64'(t.v[3+i]);
            e2[i] = 64'(t.v[6+i]) - 64'(t.v[i]);
            n[i] = 0;
        end
        ok = scale_unit(e1, EDGE_FRAC, u1);
        ok = scale_unit(e2, EDGE_FRAC, u2) && ok;
        if (ok) begin
            cr[0] = u1[1] * u2[2] - u1[2] * u2[1];
            cr[1] = u1[2] * u2[0] - u1[0] * u2[2];
            cr[2] = u1[0] * u2[1] - u1[1] * u2[0];
            ok = scale_unit(cr, OUT_FRAC, n);
        end
        if (!ok) for (int i = 0; i < 3; i++) n[i] = 0;
        r.nx = n[0][15:0];
        r.ny = n[1][15:0];
        r.nz = n[2][15:0];
        r.degen = !ok;
        return r;
    endfunction

    function automatic t_tri make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
        t_tri t;
        t.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        return t;
    endfunction

    function automatic t_row row_of(t_tri t, bit typed, int nx, int ny, int nz, bit d);
        t_row r;
        r.tri_in = t;
        r.typed = typed;
        r.want.nx = 16'(nx);
        r.want.ny = 16'(ny);
        r.want.nz = 16'(nz);
        r.want.degen = d;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            1: return $signed(32'($urandom_range(0, 255)) - 32'd128);
            2: return $signed(32'($urandom_range(0, 32'h3FFFF)) - 32'h20000);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        for (int i = 0; i < 9; i++) t.v[i] = rand_coord();
        case ($urandom_range(0, 19))
            0: for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
            1: for (int i = 0; i < 3; i++) t.v[6+i] = t.v[i];
            2: for (int i = 0; i < 3; i++) t.v[3+i] = t.v[i];
            3: for (int i = 0; i < 3; i++)
                t.v[3+i] = t.v[6+i] + 2 * (t.v[i] - t.v[6+i]);
            default: ;
        endcase
        return t;
    endfunction

    task automatic send_tri(t_tri t, bit typed, t_norm want);
        in_ch.vertex_a_x <= t.v[0];
        in_ch.vertex_a_y <= t.v[1];
        in_ch.vertex_a_z <= t.v[2];
        in_ch.vertex_b_x <= t.v[3];
        in_ch.vertex_b_y <= t.v[4];
        in_ch.vertex_b_z <= t.v[5];
        in_ch.vertex_c_x <= t.v[6];
        in_ch.vertex_c_y <= t.v[7];
        in_ch.vertex_c_z <= t.v[8];
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        normal_queue.push_back(typed ? want : face_normal(t));
        @(negedge i_clk);
    endtask

    task automatic gap();
        int n;
        n = sink_fast ? 0 : $urandom_range(0, 5);
        if (n != 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    initial begin
        t_row rows[$];
        int   big;
        int   lo;
        big = 32'sh7FFFFFFF;
        lo = 32'sh80000000;
        in_ch.valid = 1'b0;
        {in_ch.vertex_a_x, in_ch.vertex_a_y, in_ch.vertex_a_z} = '0;
        {in_ch.vertex_b_x, in_ch.vertex_b_y, in_ch.vertex_b_z} = '0;
        {in_ch.vertex_c_x, in_ch.vertex_c_y, in_ch.vertex_c_z} = '0;
        rows.push_back(row_of(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 1));
        rows.push_back(row_of(make_tri(1, 2, 3, 5, 5, 5, 5, 5, 5), 1, 0, 0, 0, 1));
        rows.push_back(row_of(make_tri(7, 7, 7, 1, 2, 3, 7, 7, 7), 1, 0, 0, 0, 1));
        rows.push_back(row_of(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2), 1, 0, 0, 0, 1));
        rows.push_back(row_of(make_tri(0, 0, 0, 0, 65536, 0, 65536, 0, 0), 1, 0, 0, 16384, 0));
        rows.push_back(row_of(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0), 1, 0, 0, -16384, 0));
        rows.push_back(row_of(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0), 1, 16384, 0, 0, 0));
        rows.push_back(row_of(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1), 1, 0, 16384, 0, 0));
        rows.push_back(row_of(make_tri(lo, lo, lo, big, big, big, big, big, big), 1,
                              0, 0, 0, 1));
        rows.push_back(row_of(make_tri(lo, lo, lo, lo, big, lo, big, lo, lo), 0, 0, 0, 0, 0));
        rows.push_back(row_of(make_tri(big, big, big, lo, lo, big, big, lo, lo), 0, 0, 0, 0, 0));
        rows.push_back(row_of(make_tri(lo, 0, big, big, lo, 0, 0, big, lo), 0, 0, 0, 0, 0));
        rows.push_back(row_of(make_tri(-1, -1, -1, 0, 0, -1, -1, 0, 0), 0, 0, 0, 0, 0));
        rows.push_back(row_of(make_tri(0, 0, 0, 1, 0, 0, big, 1, 0), 0, 0, 0, 0, 0));
        rows.push_back(row_of(make_tri(3, -5, 7, -11, 13, -17, 19, -23, 29), 0, 0, 0, 0, 0));
        rows.push_back(row_of(make_tri(lo, big, lo, big, lo, big, 0, 0, 0), 0, 0, 0, 0, 0));
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (rows[k]) begin
            send_tri(rows[k].tri_in, rows[k].typed, rows[k].want);
            gap();
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            t_norm none;
            none = '{default: 0};
            if (k == 300) begin
                hold_sink = 1'b1;
            end
            if (k == 700) begin
                in_ch.valid <= 1'b0;
                do @(negedge i_clk); while (normal_queue.size() != 0);
            end
            sink_fast = (k >= 900 && k < 1000);
            send_tri(rand_tri(), 0, none);
            gap();
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
            if (!sink_fast) begin
                int n;
                n = $urandom_range(0, 5);
                if (n != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (n - 1) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (normal_queue.size() == 0) begin
                $error("unexpected result transfer");
                n_errors++;
            end else begin
                t_norm w;
                w = normal_queue.pop_front();
                if (out_ch.normal_x !== w.nx) begin
                    $error("normal_x expected %0d actual %0d", w.nx, out_ch.normal_x);
                    n_errors++;
                end
                if (out_ch.normal_y !== w.ny) begin
                    $error("normal_y expected %0d actual %0d", w.ny, out_ch.normal_y);
                    n_errors++;
                end
                if (out_ch.normal_z !== w.nz) begin
                    $error("normal_z expected %0d actual %0d", w.nz, out_ch.normal_z);
                    n_errors++;
                end
                if (out_ch.degenerate !== w.degen) begin
                    $error("degenerate expected %0d actual %0d", w.degen,
                           out_ch.degenerate);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (stim_done && normal_queue.size() == 0 || idle_cycles >= WDOG_MAX);
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb: errors");
        end else begin
            repeat (LATENCY + 20) @(posedge i_clk);
            if (n_errors == 0 && normal_queue.size() == 0) begin
                $display("tb: clean");
            end else begin
                $display("tb: errors");
            end
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/tun_pkg.sv
design/tun_if.sv
design/tun_isqrt.sv
design/tun_div.sv
design/tun_unitize.sv
design/triangle_unit_normal.sv
tb/sv/tb.sv
